// File: src/gpu_command_packet_decoder_core_macros.svh
// Assertion macros shared by the command decoder RTL.
`ifndef GPU_COMMAND_PACKET_DECODER_CORE_MACROS_SVH
`define GPU_COMMAND_PACKET_DECODER_CORE_MACROS_SVH

// Same-cycle implication, checked on clk_i outside reset.
`define GCPD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i outside reset.
`define GCPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/gcpd_pkg.sv
// Types, codes and the packet length table of the GPU command decoder.
`default_nettype none

package gcpd_pkg;

  // What one result word reports
  typedef enum logic [1:0] {
    EV_BUFFERED = 2'd0,
    EV_UPLOAD   = 2'd1,
    EV_PACKET   = 2'd2
  } event_kind_e;

  // Decoded command class
  typedef enum logic [3:0] {
    ACT_NONE     = 4'd0,
    ACT_POLYGON  = 4'd1,
    ACT_LINE     = 4'd2,
    ACT_RECT     = 4'd3,
    ACT_COPY     = 4'd4,
    ACT_UPLOAD   = 4'd5,
    ACT_READBACK = 4'd6,
    ACT_FILL     = 4'd7,
    ACT_IRQ      = 4'd8,
    ACT_ENV      = 4'd9
  } action_e;

  // Opcode classes (top three bits of the opcode)
  localparam logic [2:0] CLS_MISC     = 3'd0;
  localparam logic [2:0] CLS_POLYGON  = 3'd1;
  localparam logic [2:0] CLS_LINE     = 3'd2;
  localparam logic [2:0] CLS_RECT     = 3'd3;
  localparam logic [2:0] CLS_COPY     = 3'd4;
  localparam logic [2:0] CLS_UPLOAD   = 3'd5;
  localparam logic [2:0] CLS_READBACK = 3'd6;

  // Individual opcodes
  localparam logic [7:0] OP_FILL       = 8'h02;
  localparam logic [7:0] OP_IRQ        = 8'h1f;
  localparam logic [7:0] OP_DRAW_MODE  = 8'he1;
  localparam logic [7:0] OP_TEX_WINDOW = 8'he2;
  localparam logic [7:0] OP_AREA_TL    = 8'he3;
  localparam logic [7:0] OP_AREA_BR    = 8'he4;
  localparam logic [7:0] OP_OFFSET     = 8'he5;
  localparam logic [7:0] OP_MASK_BITS  = 8'he6;

  localparam int unsigned WORD_COUNT_W = 4;
  localparam int unsigned HELD_DEPTH   = 3;
  localparam logic [4:0]  IRQ_BIT      = 5'd24;

  // Packet length in words for an opcode, before the cap
  function automatic logic [WORD_COUNT_W-1:0] packet_len(input logic [7:0] op);
    logic [WORD_COUNT_W-1:0] verts;
    logic [WORD_COUNT_W-1:0] n;
    verts = op[3] ? 4'd4 : 4'd3;
    case (op) inside
      [8'h00:8'h1f]: n = (op == OP_FILL) ? 4'd3 : 4'd1;
      [8'h20:8'h3f]: n = 4'd1 + (op[2] ? (verts << 1) : verts)
                         + (op[4] ? (verts - 4'd1) : 4'd0);
      [8'h40:8'h5f]: n = op[4] ? 4'd4 : 4'd3;
      [8'h60:8'h7f]: n = 4'd2 + {3'b000, op[2]} + ((op[4:3] == 2'b00) ? 4'd1 : 4'd0);
      [8'h80:8'h9f]: n = 4'd4;
      [8'ha0:8'hdf]: n = 4'd3;
      default:       n = 4'd1;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// File: src/gcpd_if.sv
// Valid/ready channels for command words and decoder results.
`default_nettype none

interface gcpd_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] port_word;

  modport source (output valid, output port_word, input ready);
  modport sink   (input valid, input port_word, output ready);
endinterface

interface gcpd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [7:0]  opcode;
  logic [3:0]  action;
  logic [31:0] status_bits;
  logic [14:0] fill_color;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [15:0] size_x;
  logic [15:0] size_y;
  logic [15:0] half_low;
  logic [15:0] half_high;
  logic [21:0] env_value;

  modport source (
    output valid, output event_kind, output opcode, output action, output status_bits,
    output fill_color, output pos_x, output pos_y, output size_x, output size_y,
    output half_low, output half_high, output env_value, input ready
  );
  modport sink (
    input valid, input event_kind, input opcode, input action, input status_bits,
    input fill_color, input pos_x, input pos_y, input size_x, input size_y,
    input half_low, input half_high, input env_value, output ready
  );
endinterface

`default_nettype wire

// File: src/gpu_command_packet_decoder_core.sv
// GPU command-port packet decoder: packet framing, decode and environment state.
// Takes one command word per cycle and returns one result word per command word; the
// result register is loaded from the input register when the result side can take it
// (one input register, one result register). Outside an upload, words are framed into
// packets by the opcode of the first word; the first three words are held, and the
// last word of a packet yields the decoded class, fill, copy, upload or readback
// parameters, environment fields and the status image. During an upload every word is
// passed out as two halfwords until width times height halfwords have gone by. The
// decode, the 16x16 size multiplier and all state updates sit in the single stage
// between the two registers, so a stall on the result side only holds the pipeline
// and a new word is taken in every cycle that the result side moves.
`default_nettype none

module gpu_command_packet_decoder_core #(
  parameter int unsigned MAX_PACKET_WORDS = 12
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  gcpd_word_if.sink           cmd_i,
  gcpd_result_if.source       res_o
);

  `include "gpu_command_packet_decoder_core_macros.svh"

  localparam logic [gcpd_pkg::WORD_COUNT_W-1:0] MaxWords =
    (gcpd_pkg::WORD_COUNT_W)'(MAX_PACKET_WORDS);

  // Input stage
  logic        in_valid_q;
  logic [31:0] word_q;
  logic        stage_fire;

  // Result register
  logic        out_valid_q;
  logic [1:0]  kind_q, kind_d;
  logic [7:0]  opcode_q, opcode_d;
  logic [3:0]  action_q, action_d;
  logic [31:0] status_out_q;
  logic [14:0] fill_color_q, fill_color_d;
  logic [15:0] pos_x_q, pos_x_d;
  logic [15:0] pos_y_q, pos_y_d;
  logic [15:0] size_x_q, size_x_d;
  logic [15:0] size_y_q, size_y_d;
  logic [15:0] half_low_q, half_low_d;
  logic [15:0] half_high_q, half_high_d;
  logic [21:0] env_value_q, env_value_d;

  // Decoder state
  logic [gcpd_pkg::WORD_COUNT_W-1:0] word_count_q, word_count_d;
  logic [31:0] held_q [gcpd_pkg::HELD_DEPTH];
  logic [31:0] held_d [gcpd_pkg::HELD_DEPTH];
  logic [31:0] status_q, status_d;
  logic [1:0]  flip_q, flip_d;
  logic [4:0]  texwin_q [4];
  logic [4:0]  texwin_d [4];
  logic [9:0]  area_q [4];
  logic [9:0]  area_d [4];
  logic [10:0] offset_q [2];
  logic [10:0] offset_d [2];
  logic        upload_active_q, upload_active_d;
  logic [31:0] upload_remaining_q, upload_remaining_d;
  logic        readback_q, readback_d;

  // Decode temporaries
  logic [gcpd_pkg::WORD_COUNT_W-1:0] count_inc;
  logic [gcpd_pkg::WORD_COUNT_W-1:0] len_raw;
  logic [gcpd_pkg::WORD_COUNT_W-1:0] len;
  logic [31:0] w0, w1, w2;
  logic [7:0]  op;
  logic [10:0] fill_w_sum;
  logic [31:0] upload_size;
  logic        upload_last;

  // Handshakes
  assign stage_fire  = in_valid_q && (!out_valid_q || res_o.ready);
  assign cmd_i.ready = !in_valid_q || stage_fire;

  // Current packet words, the incoming word standing in for its own slot
  assign w0 = (word_count_q == 4'd0) ? word_q : held_q[0];
  assign w1 = (word_count_q == 4'd1) ? word_q : held_q[1];
  assign w2 = (word_count_q == 4'd2) ? word_q : held_q[2];
  assign op = w0[31:24];

  assign count_inc   = word_count_q + 4'd1;
  assign len_raw     = gcpd_pkg::packet_len(op);
  assign len         = (len_raw > MaxWords) ? MaxWords : len_raw;
  assign fill_w_sum  = w2[10:0] + 11'h00f;
  assign upload_size = {16'd0, w2[15:0]} * {16'd0, w2[31:16]};
  assign upload_last = upload_active_q && (upload_remaining_q <= 32'd2);

  // Decode and next state
  always_comb begin
    word_count_d       = word_count_q;
    held_d             = held_q;
    status_d           = status_q;
    flip_d             = flip_q;
    texwin_d           = texwin_q;
    area_d             = area_q;
    offset_d           = offset_q;
    upload_active_d    = upload_active_q;
    upload_remaining_d = upload_remaining_q;
    readback_d         = readback_q;

    kind_d      = gcpd_pkg::EV_BUFFERED;
    opcode_d    = 8'd0;
    action_d    = gcpd_pkg::ACT_NONE;
    fill_color_d = 15'd0;
    pos_x_d     = 16'd0;
    pos_y_d     = 16'd0;
    size_x_d    = 16'd0;
    size_y_d    = 16'd0;
    half_low_d  = 16'd0;
    half_high_d = 16'd0;
    env_value_d = 22'd0;

    if (upload_active_q) begin
      // upload data word: pass both halves
      kind_d      = gcpd_pkg::EV_UPLOAD;
      action_d    = gcpd_pkg::ACT_UPLOAD;
      half_low_d  = word_q[15:0];
      half_high_d = word_q[31:16];
      if (upload_remaining_q <= 32'd2) begin
        upload_remaining_d = 32'd0;
        upload_active_d    = 1'b0;
      end else begin
        upload_remaining_d = upload_remaining_q - 32'd2;
      end
    end else begin
      if (word_count_q < 4'd3) begin
        held_d[word_count_q[1:0]] = word_q;
      end
      opcode_d = op;
      if (count_inc < len) begin
        word_count_d = count_inc;
      end else begin
        // packet complete
        word_count_d = 4'd0;
        kind_d       = gcpd_pkg::EV_PACKET;
        case (op[7:5])
          gcpd_pkg::CLS_POLYGON: action_d = gcpd_pkg::ACT_POLYGON;
          gcpd_pkg::CLS_LINE:    action_d = gcpd_pkg::ACT_LINE;
          gcpd_pkg::CLS_RECT:    action_d = gcpd_pkg::ACT_RECT;
          gcpd_pkg::CLS_COPY: begin
            action_d = gcpd_pkg::ACT_COPY;
            pos_x_d  = w1[15:0];
            pos_y_d  = w1[31:16];
          end
          gcpd_pkg::CLS_UPLOAD: begin
            action_d           = gcpd_pkg::ACT_UPLOAD;
            pos_x_d            = w1[15:0];
            pos_y_d            = w1[31:16];
            size_x_d           = w2[15:0];
            size_y_d           = w2[31:16];
            upload_remaining_d = upload_size;
            upload_active_d    = (w2[15:0] != 16'd0) && (w2[31:16] != 16'd0);
          end
          gcpd_pkg::CLS_READBACK: begin
            action_d   = gcpd_pkg::ACT_READBACK;
            pos_x_d    = w1[15:0];
            pos_y_d    = w1[31:16];
            size_x_d   = w2[15:0];
            size_y_d   = w2[31:16];
            readback_d = 1'b1;
          end
          default: begin
            // misc and environment opcodes
            case (op)
              gcpd_pkg::OP_FILL: begin
                action_d     = gcpd_pkg::ACT_FILL;
                fill_color_d = {w0[23:19], w0[15:11], w0[7:3]};
                pos_x_d      = {6'd0, w1[9:4], 4'd0};
                pos_y_d      = {7'd0, w1[24:16]};
                size_x_d     = {5'd0, fill_w_sum[10:4], 4'd0};
                size_y_d     = {7'd0, w2[24:16]};
              end
              gcpd_pkg::OP_IRQ: begin
                action_d = gcpd_pkg::ACT_IRQ;
                status_d[gcpd_pkg::IRQ_BIT] = 1'b1;
              end
              gcpd_pkg::OP_DRAW_MODE: begin
                action_d       = gcpd_pkg::ACT_ENV;
                status_d[10:0] = w0[10:0];
                status_d[15]   = w0[11];
                flip_d         = w0[13:12];
                env_value_d    = {8'd0, w0[13:0]};
              end
              gcpd_pkg::OP_TEX_WINDOW: begin
                action_d    = gcpd_pkg::ACT_ENV;
                texwin_d[0] = w0[4:0];
                texwin_d[1] = w0[9:5];
                texwin_d[2] = w0[14:10];
                texwin_d[3] = w0[19:15];
                env_value_d = {2'd0, w0[19:0]};
              end
              gcpd_pkg::OP_AREA_TL: begin
                action_d    = gcpd_pkg::ACT_ENV;
                area_d[0]   = w0[9:0];
                area_d[1]   = w0[19:10];
                env_value_d = {2'd0, w0[19:0]};
              end
              gcpd_pkg::OP_AREA_BR: begin
                action_d    = gcpd_pkg::ACT_ENV;
                area_d[2]   = w0[9:0];
                area_d[3]   = w0[19:10];
                env_value_d = {2'd0, w0[19:0]};
              end
              gcpd_pkg::OP_OFFSET: begin
                action_d    = gcpd_pkg::ACT_ENV;
                offset_d[0] = w0[10:0];
                offset_d[1] = w0[21:11];
                env_value_d = w0[21:0];
              end
              gcpd_pkg::OP_MASK_BITS: begin
                action_d        = gcpd_pkg::ACT_ENV;
                status_d[12:11] = w0[1:0];
                env_value_d     = {20'd0, w0[1:0]};
              end
              default: ;
            endcase
          end
        endcase
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q         <= 1'b0;
      out_valid_q        <= 1'b0;
      word_count_q       <= '0;
      status_q           <= 32'd0;
      flip_q             <= 2'd0;
      texwin_q           <= '{default: 5'd0};
      area_q             <= '{default: 10'd0};
      offset_q           <= '{default: 11'd0};
      upload_active_q    <= 1'b0;
      upload_remaining_q <= 32'd0;
      readback_q         <= 1'b0;
    end else begin
      if (cmd_i.ready) begin
        in_valid_q <= cmd_i.valid;
      end
      if (stage_fire) begin
        out_valid_q        <= 1'b1;
        word_count_q       <= word_count_d;
        status_q           <= status_d;
        flip_q             <= flip_d;
        texwin_q           <= texwin_d;
        area_q             <= area_d;
        offset_q           <= offset_d;
        upload_active_q    <= upload_active_d;
        upload_remaining_q <= upload_remaining_d;
        readback_q         <= readback_d;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.ready && cmd_i.valid) begin
      word_q <= cmd_i.port_word;
    end
    if (stage_fire) begin
      held_q       <= held_d;
      kind_q       <= kind_d;
      opcode_q     <= opcode_d;
      action_q     <= action_d;
      status_out_q <= status_d;
      fill_color_q <= fill_color_d;
      pos_x_q      <= pos_x_d;
      pos_y_q      <= pos_y_d;
      size_x_q     <= size_x_d;
      size_y_q     <= size_y_d;
      half_low_q   <= half_low_d;
      half_high_q  <= half_high_d;
      env_value_q  <= env_value_d;
    end
  end

  // Result word
  assign res_o.valid       = out_valid_q;
  assign res_o.event_kind  = kind_q;
  assign res_o.opcode      = opcode_q;
  assign res_o.action      = action_q;
  assign res_o.status_bits = status_out_q;
  assign res_o.fill_color  = fill_color_q;
  assign res_o.pos_x       = pos_x_q;
  assign res_o.pos_y       = pos_y_q;
  assign res_o.size_x      = size_x_q;
  assign res_o.size_y      = size_y_q;
  assign res_o.half_low    = half_low_q;
  assign res_o.half_high   = half_high_q;
  assign res_o.env_value   = env_value_q;

  // Checks
  `GCPD_ASSERT_IMPL(a_count_below_cap, 1'b1, word_count_q < MaxWords, "packet count reached cap")
  `GCPD_ASSERT_IMPL(a_upload_nonempty, upload_active_q, upload_remaining_q != '0, "empty upload")
  `GCPD_ASSERT_IMPL(a_no_packet_in_upload, upload_active_q, word_count_q == '0, "packet open")
  `GCPD_ASSERT_NEXT(a_upload_ends, stage_fire && upload_last, !upload_active_q, "upload ran on")

endmodule

`default_nettype wire

// File: tb/gpu_command_packet_decoder_core_tb.sv
// Self-checking testbench for the GPU command-port packet decoder.
`default_nettype none

module gpu_command_packet_decoder_core_tb;

  localparam int unsigned MAX_PACKET_WORDS = 12;

  // Opcodes used by the stimulus on top of the package ones
  localparam logic [7:0] OP_NOP      = 8'h00;
  localparam logic [7:0] OP_COPY     = 8'h80;
  localparam logic [7:0] OP_UPLOAD   = 8'ha0;
  localparam logic [7:0] OP_READBACK = 8'hc0;
  localparam logic [7:0] OP_ENV_BASE = 8'he0;
  localparam logic [7:0] OP_UNKNOWN  = 8'hff;

  typedef struct {
    gcpd_pkg::event_kind_e kind;
    logic [7:0]            opcode;
    gcpd_pkg::action_e     action;
    logic [31:0]           status;
    logic [14:0]           fill_color;
    logic [15:0]           pos_x;
    logic [15:0]           pos_y;
    logic [15:0]           size_x;
    logic [15:0]           size_y;
    logic [15:0]           half_low;
    logic [15:0]           half_high;
    logic [21:0]           env_value;
  } decoder_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  gcpd_word_if   cmd ();
  gcpd_result_if res ();

  gpu_command_packet_decoder_core #(
    .MAX_PACKET_WORDS(MAX_PACKET_WORDS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .res_o (res)
  );

  always #4 clk_i = ~clk_i;

  // Decoder state as the testbench sees it
  logic [3:0]  pr_word_count;
  logic [31:0] pr_held [gcpd_pkg::HELD_DEPTH];
  logic [31:0] pr_status;
  logic [1:0]  pr_flips;
  logic [4:0]  pr_tex_window [4];
  logic [9:0]  pr_area [4];
  logic [10:0] pr_offset [2];
  bit          pr_upload_active;
  logic [31:0] pr_upload_left;
  bit          pr_readback_active;

  decoder_result_t pending_results[$];

  int  mismatch_count = 0;
  int  words_sent     = 0;
  int  packets_done   = 0;
  int  data_words     = 0;
  int  results_seen   = 0;
  bit  gaps_on        = 1'b1;
  bit  stalls_on      = 1'b1;
  int  stall_left     = 0;

  // Packet length in words for an opcode, capped
  function automatic int words_in_packet(input logic [7:0] op);
    int n;
    int verts;
    verts = op[3] ? 4 : 3;
    if (op < 8'h20)      n = (op == gcpd_pkg::OP_FILL) ? 3 : 1;
    else if (op < 8'h40) n = 1 + verts * (1 + int'(op[2])) + (op[4] ? verts - 1 : 0);
    else if (op < 8'h60) n = op[4] ? 4 : 3;
    else if (op < 8'h80) n = 2 + int'(op[2]) + ((op[4:3] == 2'b00) ? 1 : 0);
    else if (op < 8'ha0) n = 4;
    else if (op < 8'he0) n = 3;
    else                 n = 1;
    return (n > MAX_PACKET_WORDS) ? MAX_PACKET_WORDS : n;
  endfunction

  // Work out the result of one accepted word and queue it
  task automatic predict_word(input logic [31:0] w);
    decoder_result_t r;
    logic [7:0]  op;
    logic [31:0] w0, w1, w2, rounded;
    r.kind = gcpd_pkg::EV_BUFFERED;  r.opcode = '0;  r.action = gcpd_pkg::ACT_NONE;
    r.status = '0;         r.fill_color = '0; r.pos_x = '0;        r.pos_y = '0;
    r.size_x = '0;         r.size_y = '0;     r.half_low = '0;     r.half_high = '0;
    r.env_value = '0;

    if (pr_upload_active) begin
      // upload data: pass both halves, count down two halfwords
      r.kind      = gcpd_pkg::EV_UPLOAD;
      r.action    = gcpd_pkg::ACT_UPLOAD;
      r.half_low  = w[15:0];
      r.half_high = w[31:16];
      if (pr_upload_left <= 32'd2) begin
        pr_upload_left   = '0;
        pr_upload_active = 1'b0;
      end else begin
        pr_upload_left = pr_upload_left - 32'd2;
      end
      data_words++;
    end else begin
      if (pr_word_count < gcpd_pkg::HELD_DEPTH) pr_held[pr_word_count[1:0]] = w;
      pr_word_count = pr_word_count + 4'd1;
      w0 = pr_held[0];
      w1 = pr_held[1];
      w2 = pr_held[2];
      op = w0[31:24];
      r.opcode = op;
      if (int'(pr_word_count) >= words_in_packet(op)) begin
        pr_word_count = '0;
        r.kind = gcpd_pkg::EV_PACKET;
        packets_done++;
        case (op[7:5])
          gcpd_pkg::CLS_POLYGON:  r.action = gcpd_pkg::ACT_POLYGON;
          gcpd_pkg::CLS_LINE:     r.action = gcpd_pkg::ACT_LINE;
          gcpd_pkg::CLS_RECT:     r.action = gcpd_pkg::ACT_RECT;
          gcpd_pkg::CLS_COPY:     r.action = gcpd_pkg::ACT_COPY;
          gcpd_pkg::CLS_UPLOAD:   r.action = gcpd_pkg::ACT_UPLOAD;
          gcpd_pkg::CLS_READBACK: r.action = gcpd_pkg::ACT_READBACK;
          default:                r.action = gcpd_pkg::ACT_NONE;
        endcase
        if (r.action == gcpd_pkg::ACT_COPY) begin
          r.pos_x = w1[15:0];
          r.pos_y = w1[31:16];
        end else if (r.action == gcpd_pkg::ACT_UPLOAD ||
                     r.action == gcpd_pkg::ACT_READBACK) begin
          r.pos_x  = w1[15:0];
          r.pos_y  = w1[31:16];
          r.size_x = w2[15:0];
          r.size_y = w2[31:16];
          if (r.action == gcpd_pkg::ACT_UPLOAD) begin
            pr_upload_left   = {16'h0, w2[15:0]} * {16'h0, w2[31:16]};
            pr_upload_active = (pr_upload_left != 0);
          end else begin
            pr_readback_active = 1'b1;
          end
        end else if (op == gcpd_pkg::OP_FILL) begin
          rounded      = w2 + 32'hf;
          r.action     = gcpd_pkg::ACT_FILL;
          r.fill_color = {w0[23:19], w0[15:11], w0[7:3]};
          r.pos_x      = {6'h0, w1[9:4], 4'h0};
          r.pos_y      = {7'h0, w1[24:16]};
          r.size_x     = {5'h0, rounded[10:4], 4'h0};
          r.size_y     = {7'h0, w2[24:16]};
        end else if (op == gcpd_pkg::OP_IRQ) begin
          r.action = gcpd_pkg::ACT_IRQ;
          pr_status[gcpd_pkg::IRQ_BIT] = 1'b1;
        end else if (op >= gcpd_pkg::OP_DRAW_MODE && op <= gcpd_pkg::OP_MASK_BITS) begin
          r.action = gcpd_pkg::ACT_ENV;
          case (op)
            gcpd_pkg::OP_DRAW_MODE: begin
              pr_status[10:0] = w0[10:0];
              pr_status[15]   = w0[11];
              pr_flips        = w0[13:12];
              r.env_value     = {8'h0, w0[13:0]};
            end
            gcpd_pkg::OP_TEX_WINDOW: begin
              for (int i = 0; i < 4; i++) pr_tex_window[i] = w0[5*i +: 5];
              r.env_value = {2'b00, w0[19:0]};
            end
            gcpd_pkg::OP_AREA_TL: begin
              pr_area[0]  = w0[9:0];
              pr_area[1]  = w0[19:10];
              r.env_value = {2'b00, w0[19:0]};
            end
            gcpd_pkg::OP_AREA_BR: begin
              pr_area[2]  = w0[9:0];
              pr_area[3]  = w0[19:10];
              r.env_value = {2'b00, w0[19:0]};
            end
            gcpd_pkg::OP_OFFSET: begin
              pr_offset[0] = w0[10:0];
              pr_offset[1] = w0[21:11];
              r.env_value  = w0[21:0];
            end
            default: begin
              pr_status[12:11] = w0[1:0];
              r.env_value      = {20'h0, w0[1:0]};
            end
          endcase
        end
      end
    end
    r.status = pr_status;
    pending_results.push_back(r);
  endtask

  // Offer one word, with an optional gap first, and wait until it is taken
  task automatic send_word(input logic [31:0] w);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      cmd.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    cmd.valid     <= 1'b1;
    cmd.port_word <= w;
    @(posedge clk_i);
    while (cmd.ready !== 1'b1) @(posedge clk_i);
    predict_word(w);
    words_sent++;
  endtask

  // Stop offering and let every queued result come out
  task automatic wait_drained();
    cmd.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Random word that never carries an upload opcode
  function automatic logic [31:0] noise_word();
    logic [31:0] w;
    w = $urandom;
    if (w[31:29] == gcpd_pkg::CLS_UPLOAD) w[31] = 1'b0;
    return w;
  endfunction

  // One well-formed packet with random content, plus its upload data
  task automatic send_packet(input logic [7:0] op);
    int          n;
    logic [31:0] w;
    logic [15:0] up_w, up_h;
    n = words_in_packet(op);
    for (int i = 0; i < n; i++) begin
      w = $urandom;
      if (i == 0) begin
        w[31:24] = op;
      end else if (i == 2 && op[7:5] == gcpd_pkg::CLS_UPLOAD) begin
        // small uploads keep the run short; zero sizes included
        up_w = 16'($urandom_range(0, 8));
        up_h = 16'($urandom_range(0, 4));
        w    = {up_h, up_w};
      end
      send_word(w);
    end
    while (pr_upload_active) send_word($urandom);
  endtask

  // Result side: ready with random stall bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else if (!stalls_on) begin
      res.ready <= 1'b1;
    end else if (stall_left > 0) begin
      res.ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      res.ready  <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      res.ready <= 1'b1;
    end
  end

  function automatic void compare_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      mismatch_count++;
    end
  endfunction

  // Check each result against the oldest expectation
  always @(posedge clk_i) begin
    decoder_result_t e;
    if (rst_ni && res.valid === 1'b1 && res.ready === 1'b1) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: kind %0h opcode %0h",
               res.event_kind, res.opcode);
        mismatch_count++;
      end else begin
        e = pending_results.pop_front();
        compare_field("event_kind",  32'(e.kind),       32'(res.event_kind));
        compare_field("opcode",      32'(e.opcode),     32'(res.opcode));
        compare_field("action",      32'(e.action),     32'(res.action));
        compare_field("status_bits", e.status,          res.status_bits);
        compare_field("fill_color",  32'(e.fill_color), 32'(res.fill_color));
        compare_field("pos_x",       32'(e.pos_x),      32'(res.pos_x));
        compare_field("pos_y",       32'(e.pos_y),      32'(res.pos_y));
        compare_field("size_x",      32'(e.size_x),     32'(res.size_x));
        compare_field("size_y",      32'(e.size_y),     32'(res.size_y));
        compare_field("half_low",    32'(e.half_low),   32'(res.half_low));
        compare_field("half_high",   32'(e.half_high),  32'(res.half_high));
        compare_field("env_value",   32'(e.env_value),  32'(res.env_value));
      end
    end
  end

  // Every environment command at its extremes, interrupt, unknown opcode, no-op
  task automatic test_environment_commands();
    send_word({gcpd_pkg::OP_DRAW_MODE,  24'hffffff});
    send_word({gcpd_pkg::OP_TEX_WINDOW, 24'hffffff});
    send_word({gcpd_pkg::OP_AREA_TL,    24'hffffff});
    send_word({gcpd_pkg::OP_AREA_BR,    24'h000000});
    send_word({gcpd_pkg::OP_OFFSET,     24'hffffff});
    send_word({gcpd_pkg::OP_MASK_BITS,  24'hffffff});
    send_word({gcpd_pkg::OP_IRQ,        24'h000000});
    send_word({OP_UNKNOWN,              24'h5a5a5a});
    send_word({OP_NOP,                  24'h000000});
  endtask

  // Fill, a copy, readback, an odd-sized upload and empty uploads
  task automatic test_fill_copy_upload();
    send_word({gcpd_pkg::OP_FILL, 24'hffffff});
    send_word(32'hffffffff);
    send_word(32'hffffffff);
    send_word({OP_COPY, 24'h000000});
    send_word(32'h01230456);
    send_word(32'h00200010);
    send_word(32'h00100008);
    send_word({OP_READBACK, 24'h000000});
    send_word(32'h00000000);
    send_word(32'hffffffff);
    // three halfwords: the second data word carries the last one
    send_word({OP_UPLOAD, 24'h000000});
    send_word(32'h00100020);
    send_word(32'h00010003);
    send_word(32'hffffffff);
    send_word(32'h00000000);
    // zero height, then zero width: no upload starts
    send_word({OP_UPLOAD, 24'hffffff});
    send_word(32'hffffffff);
    send_word(32'h0000ffff);
    send_word({OP_UPLOAD, 24'h000000});
    send_word(32'h00000000);
    send_word(32'hffff0000);
  endtask

  // Mostly well-formed packets, some stray words that break framing
  task automatic test_random_traffic(input int word_budget, input bit pause_midway);
    int          stop_at;
    int          pause_at;
    bit          paused;
    logic [7:0]  op;
    stop_at  = words_sent + word_budget;
    pause_at = words_sent + word_budget / 2;
    paused   = 1'b0;
    while (words_sent < stop_at) begin
      if (pause_midway && !paused && words_sent >= pause_at) begin
        wait_drained();
        paused = 1'b1;
      end
      if ($urandom_range(0, 11) == 0) begin
        // stray word, then pad the packet it opened so framing is known again
        send_word(noise_word());
        while (pr_word_count != 0) send_word(noise_word());
      end else begin
        case ($urandom_range(0, 5))
          0:       op = OP_ENV_BASE + 8'($urandom_range(0, 7));
          1:       op = $urandom_range(0, 1) ? gcpd_pkg::OP_FILL : gcpd_pkg::OP_IRQ;
          2:       op = OP_UPLOAD | 8'($urandom_range(0, 31));
          default: op = 8'($urandom_range(0, 255));
        endcase
        send_packet(op);
      end
    end
  endtask

  // Tail of the run at full rate on both sides
  task automatic test_back_to_back();
    wait_drained();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    test_random_traffic(330, 1'b0);
  endtask

  initial begin
    cmd.valid     = 1'b0;
    cmd.port_word = '0;
    pr_word_count      = '0;
    pr_status          = '0;
    pr_flips           = '0;
    pr_upload_active   = 1'b0;
    pr_upload_left     = '0;
    pr_readback_active = 1'b0;
    for (int i = 0; i < gcpd_pkg::HELD_DEPTH; i++) pr_held[i] = '0;
    for (int i = 0; i < 4; i++) begin
      pr_tex_window[i] = '0;
      pr_area[i]       = '0;
    end
    pr_offset[0] = '0;
    pr_offset[1] = '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_environment_commands();
    test_fill_copy_upload();
    test_random_traffic(1390, 1'b1);
    test_back_to_back();

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never came", pending_results.size());
    end
    $display("Sent %0d command words: %0d packets and %0d upload data words.",
             words_sent, packets_done, data_words);
    $display("Checked %0d results under random gaps and stalls, a drained pause, full rate.",
             results_seen);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire
